FILE: rtl/signed_binary_to_decimal_ascii_assert.svh
// assertion macros for the signed binary to decimal ascii converter
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define SBDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbda: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbda: next-cycle check failed");

`endif

FILE: rtl/sbda_pkg.sv
// shared types and constants for the signed binary to decimal ascii converter
`default_nettype none

package sbda_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_SLOTS = 10;

    localparam int S_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CHAR_W    = 6;
    localparam int M_TDATA_W = 8;
    localparam int BCD_W     = 4 * DIGIT_SLOTS;
    localparam int CNT_W     = $clog2(VALUE_BITS);
    localparam int REM_W     = $clog2(DIGIT_SLOTS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic rem_one;
        logic sign_pending;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/sbda_dpath.sv
// datapath: magnitude, shift-add-3 digit register, character output register
`default_nettype none

module sbda_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [sbda_pkg::VALUE_BITS-1:0] value,
    input  wire sbda_pkg::cmd_t                cmd,
    output sbda_pkg::status_t                  status,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sbda_pkg::CHAR_W-1:0]        m_char,
    output logic                               m_last
);

    logic [sbda_pkg::VALUE_BITS-1:0] mag_reg, mag_next;
    logic [sbda_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic [sbda_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [sbda_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic                            neg_reg, neg_next;
    logic                            valid_reg, valid_next;
    logic [sbda_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                            last_reg, last_next;
    logic [sbda_pkg::BCD_W-1:0]      bcd_adj;
    logic [3:0]                      top_digit;

    assign top_digit = bcd_reg[sbda_pkg::BCD_W-1 -: 4];

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < sbda_pkg::DIGIT_SLOTS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end

        if (cmd.load) begin
            neg_next = value[sbda_pkg::VALUE_BITS-1];
            mag_next = value[sbda_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;
            bcd_next = '0;
            cnt_next = '0;
            rem_next = sbda_pkg::REM_W'(sbda_pkg::DIGIT_SLOTS);
        end else if (cmd.step) begin
            bcd_next = {bcd_adj[sbda_pkg::BCD_W-2:0], mag_reg[sbda_pkg::VALUE_BITS-1]};
            mag_next = {mag_reg[sbda_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end else if (cmd.skip) begin
            bcd_next = {bcd_reg[sbda_pkg::BCD_W-5:0], 4'd0};
            rem_next = rem_reg - 1'b1;
        end else if (cmd.emit) begin
            valid_next = 1'b1;
            if (neg_reg) begin
                char_next = sbda_pkg::CHAR_MINUS;
                last_next = 1'b0;
                neg_next  = 1'b0;
            end else begin
                char_next = sbda_pkg::CHAR_ZERO + {2'b00, top_digit};
                last_next = (rem_reg == sbda_pkg::REM_W'(1));
                bcd_next  = {bcd_reg[sbda_pkg::BCD_W-5:0], 4'd0};
                rem_next  = rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            neg_reg   <= neg_next;
            valid_reg <= valid_next;
        end
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.conv_done    = (cnt_reg == sbda_pkg::CNT_W'(sbda_pkg::VALUE_BITS - 1));
    assign status.top_zero     = (top_digit == 4'd0);
    assign status.rem_one      = (rem_reg == sbda_pkg::REM_W'(1));
    assign status.sign_pending = neg_reg;
    assign status.out_free     = !valid_reg || m_ready;

    assign m_valid = valid_reg;
    assign m_char  = char_reg;
    assign m_last  = last_reg;

endmodule

`default_nettype wire

FILE: rtl/sbda_ctrl.sv
// controller: sequences load, conversion, zero skip and character emission
`default_nettype none

module sbda_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sbda_pkg::status_t status,
    output sbda_pkg::cmd_t         cmd,
    output sbda_pkg::state_t       state
);

    sbda_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sbda_pkg::ST_IDLE: begin
                // nothing is taken while reset is held
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = sbda_pkg::ST_CONV;
                end
            end
            sbda_pkg::ST_CONV: begin
                cmd.step = 1'b1;
                if (status.conv_done) begin
                    state_next = sbda_pkg::ST_SKIP;
                end
            end
            sbda_pkg::ST_SKIP: begin
                // drop leading zero digits, keep at least one
                if (status.top_zero && !status.rem_one) begin
                    cmd.skip = 1'b1;
                end else begin
                    state_next = sbda_pkg::ST_EMIT;
                end
            end
            sbda_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (!status.sign_pending && status.rem_one) begin
                        state_next = sbda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

FILE: rtl/signed_binary_to_decimal_ascii.sv
// top level of the signed binary to decimal ascii converter
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tdata: value (32 bits, signed)
// m_       out  m_tvalid/m_tready   m_tdata: character (6 bits), m_tlast: last
//
// a value is accepted, shifted in by one shift-add-3 step per value bit, stripped of its
// leading zero digits and printed as characters, a minus sign first when negative; dropped
// and printed digits make 10 in all
// synchronous active-low reset clears the controller and the output valid, s_tready low
// a stalled output holds the sequencer in emission; a finished last character
// may wait in the output register while the next value is taken
`default_nettype none

module signed_binary_to_decimal_ascii (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [sbda_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [sbda_pkg::M_TDATA_W-1:0]    m_tdata,  // [5:0] character, [7:6] zero
    output logic                              m_tlast
);

    `include "signed_binary_to_decimal_ascii_assert.svh"

    sbda_pkg::cmd_t               cmd;
    sbda_pkg::status_t            status;
    sbda_pkg::state_t             state;
    logic [sbda_pkg::CHAR_W-1:0]  m_char;
    logic                         in_emit;
    logic                         char_legal;

    // sequencer for one value at a time
    sbda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    // only the low value bits carry data; byte padding is ignored
    sbda_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .value   (s_tdata[sbda_pkg::VALUE_BITS-1:0]),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_char  (m_char),
        .m_last  (m_tlast)
    );

    assign m_tdata = {{(sbda_pkg::M_TDATA_W - sbda_pkg::CHAR_W){1'b0}}, m_char};

    assign in_emit    = (state == sbda_pkg::ST_EMIT);
    assign char_legal = (m_char == sbda_pkg::CHAR_MINUS) ||
                        ((m_char >= sbda_pkg::CHAR_ZERO) &&
                         (m_char <= sbda_pkg::CHAR_ZERO + 6'd9));

    // once a value is taken the block is busy with its conversion
    `SBDA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a non-final character on the output means the run is still being emitted
    `SBDA_ASSERT_SAME(a_run_in_emit, aclk, aresetn, m_tvalid && !m_tlast, in_emit)

    // only a minus sign or a decimal digit ever appears on the output
    `SBDA_ASSERT_SAME(a_char_legal, aclk, aresetn, m_tvalid, char_legal)

endmodule

`default_nettype wire
